>>> sv/bed_pkg.sv
// Types, character codes and lookup functions for the backslash escape decoder.
`timescale 1ns / 1ps

package bed_pkg;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_LOWER_A   = 8'h61;
   localparam logic [7:0] CH_LOWER_B   = 8'h62;
   localparam logic [7:0] CH_LOWER_C   = 8'h63;
   localparam logic [7:0] CH_LOWER_E   = 8'h65;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CH_LOWER_V   = 8'h76;
   localparam logic [7:0] CH_LOWER_X   = 8'h78;
   localparam logic [7:0] CH_UPPER_A   = 8'h41;
   localparam logic [7:0] CH_UPPER_F   = 8'h46;
   localparam logic [7:0] CH_DIGIT_0   = 8'h30;
   localparam logic [7:0] CH_DIGIT_1   = 8'h31;
   localparam logic [7:0] CH_DIGIT_7   = 8'h37;
   localparam logic [7:0] CH_DIGIT_9   = 8'h39;

   localparam logic [7:0] BYTE_BELL      = 8'd7;
   localparam logic [7:0] BYTE_BACKSPACE = 8'd8;
   localparam logic [7:0] BYTE_TAB       = 8'd9;
   localparam logic [7:0] BYTE_LINEFEED  = 8'd10;
   localparam logic [7:0] BYTE_VTAB      = 8'd11;
   localparam logic [7:0] BYTE_FORMFEED  = 8'd12;
   localparam logic [7:0] BYTE_CR        = 8'd13;
   localparam logic [7:0] BYTE_ESCAPE    = 8'd27;
   localparam logic [7:0] BYTE_ZERO      = 8'd0;

   localparam logic [1:0] HEX_MAX_DIGITS = 2'd2;
   localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

   typedef enum logic [1:0] {
      PH_TEXT,
      PH_ESC,
      PH_HEX,
      PH_OCT
   } phase_type;

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  acc;
      logic [1:0]  cnt;
      logic        stopped;
   } state_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        stop_marker;
      logic        string_end_out;
      logic        last_of_run;
   } result_type;

   typedef struct packed {
      logic        space_ok;
      logic        not_empty;
   } fifo_status_type;

   typedef struct packed {
      logic        hit;
      logic [3:0]  value;
   } digit_type;

   typedef struct packed {
      logic        hit;
      logic [7:0]  value;
   } esc_type;

   function automatic digit_type hex_digit(input logic [7:0] ch);
      digit_type d;
      d = '0;
      if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
         d.hit   = 1'b1;
         d.value = 4'(ch - CH_DIGIT_0);
      end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_F) begin
         d.hit   = 1'b1;
         d.value = 4'(ch - CH_LOWER_A + 8'd10);
      end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) begin
         d.hit   = 1'b1;
         d.value = 4'(ch - CH_UPPER_A + 8'd10);
      end
      return d;
   endfunction

   function automatic esc_type simple_escape(input logic [7:0] ch);
      esc_type e;
      e.hit = 1'b1;
      case (ch)
         CH_LOWER_A:   e.value = BYTE_BELL;
         CH_LOWER_B:   e.value = BYTE_BACKSPACE;
         CH_LOWER_E:   e.value = BYTE_ESCAPE;
         CH_LOWER_F:   e.value = BYTE_FORMFEED;
         CH_LOWER_N:   e.value = BYTE_LINEFEED;
         CH_LOWER_R:   e.value = BYTE_CR;
         CH_LOWER_T:   e.value = BYTE_TAB;
         CH_LOWER_V:   e.value = BYTE_VTAB;
         CH_BACKSLASH: e.value = CH_BACKSLASH;
         CH_QUOTE:     e.value = CH_QUOTE;
         default: begin
            e.hit   = 1'b0;
            e.value = BYTE_ZERO;
         end
      endcase
      return e;
   endfunction

endpackage

>>> sv/backslash_escape_decoder.sv
// Top level: request register, decode state, mode register and result queue.
//
//   port group | direction | handshake          | payload
//   req_       | in        | req_valid/req_stall | req_char_in, req_string_end_in
//   rsp_       | out       | rsp_valid/rsp_stall | rsp_out_byte, rsp_stop_marker,
//              |           |                     | rsp_string_end_out, rsp_last_of_run
//   csr_       | in        | csr_wr_en           | csr_wr_data (bare octal mode)
//
// A request is held in the request register and decoded from there; its results go into
// the result queue, which offers them. One request per cycle is taken while req_stall is low;
// a request giving two results hands them out one at a time through the single result port.
// Reset clears the decode state, the mode bit and the queue; no clearing pass.
// req_stall rises only while the four-entry result queue cannot take two more results.
`timescale 1ns / 1ps

module backslash_escape_decoder import bed_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_in,
   input  logic        req_string_end_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_stop_marker,
   output logic        rsp_string_end_out,
   output logic        rsp_last_of_run
);

   logic             mode_ff;
   logic             req_valid_ff, req_valid_in;
   logic [7:0]       req_char_ff;
   logic             req_end_ff;
   state_type        state_ff, state_in;
   state_type        state_dec;
   result_type       res0, res1, head;
   logic [1:0]       res_count;
   logic [1:0]       push_count;
   logic             consume;
   fifo_status_type  fifo_status;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else if (csr_wr_en) begin
         mode_ff <= csr_wr_data;
      end
   end

   assign consume      = req_valid_ff && fifo_status.space_ok;
   assign req_stall    = req_valid_ff && !fifo_status.space_ok;
   assign req_valid_in = req_stall ? req_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_char_ff <= req_char_in;
         req_end_ff  <= req_string_end_in;
      end
   end

   bed_decode u_decode (
      .state_cur       (state_ff),
      .char_in         (req_char_ff),
      .string_end_in   (req_end_ff),
      .bare_octal_mode (mode_ff),
      .state_nxt       (state_dec),
      .res0            (res0),
      .res1            (res1),
      .res_count       (res_count)
   );

   always_comb begin
      state_in   = consume ? state_dec : state_ff;
      push_count = consume ? res_count : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_TEXT, acc: 8'd0, cnt: 2'd0, stopped: 1'b0};
      end else begin
         state_ff <= state_in;
      end
   end

   bed_result_fifo u_result_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data0 (res0),
      .push_data1 (res1),
      .pop        (rsp_valid && !rsp_stall),
      .head       (head),
      .status     (fifo_status)
   );

   assign rsp_valid          = fifo_status.not_empty;
   assign rsp_out_byte       = head.out_byte;
   assign rsp_stop_marker    = head.stop_marker;
   assign rsp_string_end_out = head.string_end_out;
   assign rsp_last_of_run    = head.last_of_run;

endmodule

>>> sv/bed_decode.sv
// Per-character decode: next state and up to two result entries.
`timescale 1ns / 1ps

module bed_decode import bed_pkg::*; (
   input  state_type   state_cur,
   input  logic [7:0]  char_in,
   input  logic        string_end_in,
   input  logic        bare_octal_mode,
   output state_type   state_nxt,
   output result_type  res0,
   output result_type  res1,
   output logic [1:0]  res_count
);

   result_type res [2];
   logic [1:0] n;
   logic       used;
   digit_type  hd;
   esc_type    se;
   logic [1:0] cnt_inc;

   always_comb begin
      state_nxt = state_cur;
      res[0]    = '0;
      res[1]    = '0;
      n         = 2'd0;
      used      = 1'b0;
      hd        = hex_digit(char_in);
      se        = simple_escape(char_in);
      cnt_inc   = state_cur.cnt + 2'd1;

      if (!state_cur.stopped) begin
         unique case (state_cur.phase)
            PH_HEX: begin
               if (hd.hit) begin
                  state_nxt.acc = {state_cur.acc[3:0], hd.value};
                  state_nxt.cnt = cnt_inc;
                  if (cnt_inc >= HEX_MAX_DIGITS) begin
                     res[n[0]].out_byte = state_nxt.acc;
                     n = n + 2'd1;
                     state_nxt.phase = PH_TEXT;
                  end
                  used = 1'b1;
               end else begin
                  res[n[0]].out_byte = (state_cur.cnt != 2'd0) ? state_cur.acc : CH_LOWER_X;
                  n = n + 2'd1;
                  state_nxt.phase = PH_TEXT;
               end
            end
            PH_OCT: begin
               if (char_in >= CH_DIGIT_0 && char_in <= CH_DIGIT_7) begin
                  state_nxt.acc = {state_cur.acc[4:0], char_in[2:0]};
                  state_nxt.cnt = cnt_inc;
                  if (cnt_inc >= OCT_MAX_DIGITS) begin
                     res[n[0]].out_byte = state_nxt.acc;
                     n = n + 2'd1;
                     state_nxt.phase = PH_TEXT;
                  end
                  used = 1'b1;
               end else begin
                  res[n[0]].out_byte = state_cur.acc;
                  n = n + 2'd1;
                  state_nxt.phase = PH_TEXT;
               end
            end
            PH_TEXT, PH_ESC: begin
            end
            default: begin
            end
         endcase

         if (!used) begin
            if (state_nxt.phase == PH_TEXT) begin
               if (char_in == CH_BACKSLASH) begin
                  state_nxt.phase = PH_ESC;
               end else begin
                  res[n[0]].out_byte = char_in;
                  n = n + 2'd1;
               end
            end else begin
               state_nxt.phase = PH_TEXT;
               state_nxt.acc   = 8'd0;
               state_nxt.cnt   = 2'd0;
               if (char_in == CH_LOWER_C) begin
                  state_nxt.stopped     = 1'b1;
                  res[n[0]].out_byte    = BYTE_ZERO;
                  res[n[0]].stop_marker = 1'b1;
                  n = n + 2'd1;
               end else if (char_in == CH_LOWER_X) begin
                  state_nxt.phase = PH_HEX;
               end else if (char_in == CH_DIGIT_0) begin
                  state_nxt.phase = PH_OCT;
               end else if (se.hit) begin
                  res[n[0]].out_byte = se.value;
                  n = n + 2'd1;
               end else if (bare_octal_mode && char_in >= CH_DIGIT_1
                            && char_in <= CH_DIGIT_7) begin
                  state_nxt.phase = PH_OCT;
                  state_nxt.acc   = {5'd0, char_in[2:0]};
                  state_nxt.cnt   = 2'd1;
               end else begin
                  res[0].out_byte = CH_BACKSLASH;
                  res[1].out_byte = char_in;
                  n = 2'd2;
               end
            end
         end

         if (string_end_in && !state_nxt.stopped) begin
            unique case (state_nxt.phase)
               PH_HEX: begin
                  res[n[0]].out_byte = (state_nxt.cnt != 2'd0) ? state_nxt.acc : CH_LOWER_X;
                  n = n + 2'd1;
               end
               PH_OCT: begin
                  res[n[0]].out_byte = state_nxt.acc;
                  n = n + 2'd1;
               end
               PH_ESC: begin
                  res[n[0]].out_byte = CH_BACKSLASH;
                  n = n + 2'd1;
               end
               PH_TEXT: begin
               end
               default: begin
               end
            endcase
            state_nxt.phase = PH_TEXT;
            state_nxt.acc   = 8'd0;
            state_nxt.cnt   = 2'd0;
         end
      end

      if (n == 2'd2) begin
         res[1].last_of_run    = 1'b1;
         res[1].string_end_out = string_end_in;
      end else if (n == 2'd1) begin
         res[0].last_of_run    = 1'b1;
         res[0].string_end_out = string_end_in;
      end
   end

   assign res0      = res[0];
   assign res1      = res[1];
   assign res_count = n;

endmodule

>>> sv/bed_result_fifo.sv
// Result queue: takes up to two results a cycle, hands out one.
`timescale 1ns / 1ps

module bed_result_fifo import bed_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_count,
   input  result_type       push_data0,
   input  result_type       push_data1,
   input  logic             pop,
   output result_type       head,
   output fifo_status_type  status
);

   result_type             mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  count_ff, count_in;
   logic [FIFO_PTR_W-1:0]  wr_ptr_next;

   assign wr_ptr_next = wr_ptr_ff + FIFO_PTR_W'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(pop);
      count_in  = count_ff + FIFO_CNT_W'(push_count) - FIFO_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_data0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push_data1;
      end
   end

   assign head   = mem_ff[rd_ptr_ff];
   assign status = {(count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2)), (count_ff != '0)};

endmodule

>>> tb/tb_backslash_escape_decoder.sv
// Self-checking testbench for the backslash escape decoder: directed strings, random strings.
`timescale 1ns / 1ps

module tb_backslash_escape_decoder;
   import bed_pkg::*;

   class escape_ledger;
      phase_type   phase;
      logic [7:0]  acc;
      logic [1:0]  ndig;
      logic        stopped;
      logic        bare_octal;
      int unsigned produced;
      int unsigned errors;
      result_type  owed[$];

      function new();
         phase      = PH_TEXT;
         acc        = '0;
         ndig       = '0;
         stopped    = 1'b0;
         bare_octal = 1'b0;
         errors     = 0;
      endfunction

      function int nibble_of(logic [7:0] ch);
         if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) return int'(ch - CH_DIGIT_0);
         if (ch >= CH_LOWER_A && ch <= CH_LOWER_F) return int'(ch - CH_LOWER_A) + 10;
         if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) return int'(ch - CH_UPPER_A) + 10;
         return -1;
      endfunction

      function void emit(logic [7:0] b, logic stop);
         result_type r;
         r.out_byte       = b;
         r.stop_marker    = stop;
         r.string_end_out = 1'b0;
         r.last_of_run    = 1'b0;
         owed.push_back(r);
         produced++;
      endfunction

      function void take_char(logic [7:0] ch, logic fin);
         int         hv;
         logic       used;
         result_type r;
         used     = 1'b0;
         produced = 0;
         if (stopped) return;
         if (phase == PH_HEX) begin
            hv = nibble_of(ch);
            if (hv >= 0) begin
               acc  = {acc[3:0], hv[3:0]};
               ndig = ndig + 2'd1;
               if (ndig >= HEX_MAX_DIGITS) begin
                  emit(acc, 1'b0);
                  phase = PH_TEXT;
               end
               used = 1'b1;
            end else begin
               emit(ndig != 0 ? acc : CH_LOWER_X, 1'b0);
               phase = PH_TEXT;
            end
         end else if (phase == PH_OCT) begin
            if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_7) begin
               acc  = {acc[4:0], 3'(ch - CH_DIGIT_0)};
               ndig = ndig + 2'd1;
               if (ndig >= OCT_MAX_DIGITS) begin
                  emit(acc, 1'b0);
                  phase = PH_TEXT;
               end
               used = 1'b1;
            end else begin
               emit(acc, 1'b0);
               phase = PH_TEXT;
            end
         end
         if (!used) begin
            if (phase == PH_TEXT) begin
               if (ch == CH_BACKSLASH) phase = PH_ESC;
               else emit(ch, 1'b0);
            end else begin
               phase = PH_TEXT;
               acc   = '0;
               ndig  = '0;
               case (ch)
                  CH_LOWER_A:   emit(BYTE_BELL, 1'b0);
                  CH_LOWER_B:   emit(BYTE_BACKSPACE, 1'b0);
                  CH_LOWER_E:   emit(BYTE_ESCAPE, 1'b0);
                  CH_LOWER_F:   emit(BYTE_FORMFEED, 1'b0);
                  CH_LOWER_N:   emit(BYTE_LINEFEED, 1'b0);
                  CH_LOWER_R:   emit(BYTE_CR, 1'b0);
                  CH_LOWER_T:   emit(BYTE_TAB, 1'b0);
                  CH_LOWER_V:   emit(BYTE_VTAB, 1'b0);
                  CH_BACKSLASH: emit(CH_BACKSLASH, 1'b0);
                  CH_QUOTE:     emit(CH_QUOTE, 1'b0);
                  CH_LOWER_C: begin
                     stopped = 1'b1;
                     emit(BYTE_ZERO, 1'b1);
                  end
                  CH_LOWER_X:   phase = PH_HEX;
                  CH_DIGIT_0:   phase = PH_OCT;
                  default: begin
                     if (bare_octal && ch >= CH_DIGIT_1 && ch <= CH_DIGIT_7) begin
                        phase = PH_OCT;
                        acc   = ch - CH_DIGIT_0;
                        ndig  = 2'd1;
                     end else begin
                        emit(CH_BACKSLASH, 1'b0);
                        emit(ch, 1'b0);
                     end
                  end
               endcase
            end
         end
         if (fin && !stopped) begin
            case (phase)
               PH_HEX:  emit(ndig != 0 ? acc : CH_LOWER_X, 1'b0);
               PH_OCT:  emit(acc, 1'b0);
               PH_ESC:  emit(CH_BACKSLASH, 1'b0);
               default: ;
            endcase
            phase = PH_TEXT;
            acc   = '0;
            ndig  = '0;
         end
         if (produced != 0) begin
            r = owed.pop_back();
            r.last_of_run    = 1'b1;
            r.string_end_out = fin;
            owed.push_back(r);
         end
      endfunction

      function void match_byte(logic [7:0] b, logic stop, logic fin, logic last);
         result_type want;
         if (owed.size() == 0) begin
            $error("unexpected result: out_byte %0h stop_marker %0b", b, stop);
            errors++;
            return;
         end
         want = owed.pop_front();
         if (b !== want.out_byte) begin
            $error("out_byte: expected %0h, actual %0h", want.out_byte, b);
            errors++;
         end
         if (stop !== want.stop_marker) begin
            $error("stop_marker: expected %0b, actual %0b", want.stop_marker, stop);
            errors++;
         end
         if (fin !== want.string_end_out) begin
            $error("string_end_out: expected %0b, actual %0b", want.string_end_out, fin);
            errors++;
         end
         if (last !== want.last_of_run) begin
            $error("last_of_run: expected %0b, actual %0b", want.last_of_run, last);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_char_in = 8'h41;
   logic        req_string_end_in = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_stop_marker;
   logic        rsp_string_end_out;
   logic        rsp_last_of_run;

   escape_ledger ledger = new();
   int unsigned  idle_pct = 24;
   int unsigned  stall_pct = 24;
   int unsigned  n_sent = 0;
   logic         allow_stop = 1'b0;
   logic         hold_active = 1'b0;
   event         hold_off;

   logic [7:0] simple_set [10] = '{CH_LOWER_A, CH_LOWER_B, CH_LOWER_E, CH_LOWER_F, CH_LOWER_N,
                                   CH_LOWER_R, CH_LOWER_T, CH_LOWER_V, CH_BACKSLASH, CH_QUOTE};

   backslash_escape_decoder dut (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_char_in        (req_char_in),
      .req_string_end_in  (req_string_end_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_stop_marker    (rsp_stop_marker),
      .rsp_string_end_out (rsp_string_end_out),
      .rsp_last_of_run    (rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_req(input logic [7:0] ch_in, input logic fin);
      logic [7:0] ch;
      ch = ch_in;
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      // keep the stop escape for the end of the run
      if (!allow_stop && ledger.phase == PH_ESC && ch == CH_LOWER_C) ch = CH_LOWER_N;
      req_valid         <= 1'b1;
      req_char_in       <= ch;
      req_string_end_in <= fin;
      do @(posedge clock); while (req_stall);
      ledger.take_char(ch, fin);
      n_sent++;
   endtask

   task automatic send_text(input string s, input logic fin_last);
      for (int i = 0; i < s.len(); i++) send_req(s[i], fin_last && i == s.len() - 1);
   endtask

   task automatic rand_send(input logic [7:0] ch);
      send_req(ch, $urandom_range(11) == 0);
   endtask

   task automatic send_token();
      int unsigned kind;
      int unsigned v;
      logic [7:0]  ch;
      kind = $urandom_range(99);
      if (kind < 30) begin
         ch = 8'($urandom_range(1, 255));
         if (ch == CH_BACKSLASH) ch = CH_QUOTE;
         rand_send(ch);
      end else if (kind < 50) begin
         rand_send(CH_BACKSLASH);
         rand_send(simple_set[$urandom_range(9)]);
      end else if (kind < 62) begin
         rand_send(CH_BACKSLASH);
         rand_send(CH_LOWER_X);
         repeat ($urandom_range(3)) begin
            v = $urandom_range(15);
            if (v < 10) ch = CH_DIGIT_0 + 8'(v);
            else ch = ($urandom_range(1) ? CH_LOWER_A : CH_UPPER_A) + 8'(v - 10);
            rand_send(ch);
         end
      end else if (kind < 76) begin
         rand_send(CH_BACKSLASH);
         rand_send($urandom_range(1) ? CH_DIGIT_0 : CH_DIGIT_1 + 8'($urandom_range(6)));
         repeat ($urandom_range(3)) rand_send(CH_DIGIT_0 + 8'($urandom_range(7)));
      end else if (kind < 84) begin
         rand_send(CH_BACKSLASH);
         rand_send(8'($urandom_range(1, 255)));
      end else begin
         rand_send(8'($urandom_range(1, 255)));
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (ledger.owed.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      ledger.bare_octal = m;
   endtask

   task automatic random_phase(input logic m, input int unsigned count);
      int unsigned target;
      target = n_sent + count;
      write_mode(m);
      while (n_sent < target) send_token();
      drain();
   endtask

   initial begin : receiver
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            ledger.match_byte(rsp_out_byte, rsp_stop_marker, rsp_string_end_out,
                              rsp_last_of_run);
         if (hold_active) rsp_stall <= 1'b1;
         else rsp_stall <= stall_pct != 0 && $urandom_range(99) < stall_pct;
      end
   end

   initial begin : long_hold
      @(hold_off);
      hold_active = 1'b1;
      repeat (400) @(posedge clock);
      hold_active = 1'b0;
   end

   initial begin : timeout
      #5_000_000;
      $display("** backslash_escape_decoder: FAILED **");
      $finish;
   end

   initial begin : stimulus
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      write_mode(1'b0);
      send_req(8'h01, 1'b0);
      send_req(8'hFF, 1'b0);
      send_req(8'h00, 1'b0);
      send_text("\\n\\x4f\\xz\\0777\\q\\", 1'b1);
      drain();

      write_mode(1'b1);
      send_text("\\52", 1'b1);
      send_text("\\9\\x", 1'b1);
      drain();

      -> hold_off;
      random_phase(1'b1, 460);
      idle_pct  = 0;
      stall_pct = 0;
      random_phase(1'b0, 460);
      idle_pct  = 24;
      stall_pct = 24;
      random_phase(1'b1, 460);
      random_phase(1'b0, 460);

      // close any open string, stop, then confirm silence
      send_req(CH_QUOTE, 1'b1);
      allow_stop = 1'b1;
      send_text("\\c", 1'b0);
      send_text("ab\\", 1'b1);
      drain();

      if (ledger.errors == 0 && ledger.owed.size() == 0)
         $display("** backslash_escape_decoder: PASSED **");
      else
         $display("** backslash_escape_decoder: FAILED **");
      $finish;
   end

endmodule

>>> backslash_escape_decoder.f
sv/bed_pkg.sv
sv/bed_decode.sv
sv/bed_result_fifo.sv
sv/backslash_escape_decoder.sv
tb/tb_backslash_escape_decoder.sv
